>>> rtl/core/ffha_pkg.sv
// Shared types, codes and defaults for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int unsigned ARENA_BYTES_DEF  = 1048576;
  localparam int unsigned HEADER_BYTES_DEF = 12;
  localparam int unsigned MAX_BLOCKS_DEF   = 1024;

  localparam logic [31:0] HEAP_BASE_RST = 32'h0040_0000;
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned REQ_W         = 21;
  localparam int unsigned RSIZE_W       = REQ_W + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef struct packed {
    logic             opcode;
    logic [REQ_W-1:0] request_size;
    logic [31:0]      free_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_LOAD,
    CMD_RD,
    CMD_FAIL,
    CMD_TAKE,
    CMD_HOLD,
    CMD_ADV,
    CMD_UP_RD,
    CMD_UP_WR,
    CMD_SPL1,
    CMD_SPL0,
    CMD_NEXT,
    CMD_MERGE,
    CMD_DN_RD,
    CMD_DN_WR,
    CMD_DN_END,
    CMD_PUT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic stop;
    logic hit_alloc;
    logic can_split;
    logic hit_free;
    logic up_more;
    logic dn_more;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/core/ffha_ctrl.sv
// Sequencer for the allocator: walks the block table through datapath commands.
`timescale 1ns / 1ps
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_UP_RD, S_UP_WR, S_SPL1, S_SPL0,
    S_NX, S_MRG, S_DN_RD, S_DN_WR, S_PUT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  always_comb begin
    state_d = state_q;
    stall_d = stall_q;
    cmd_o.op = CMD_NONE;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = CMD_INIT;
        state_d  = S_IDLE;
        stall_d  = 1'b0;
      end
      S_IDLE: begin
        if (in_valid_i && !stall_q) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_RD;
          stall_d  = 1'b1;
        end
      end
      S_RD: begin
        if (sts_i.stop) begin
          cmd_o.op = CMD_FAIL;
          state_d  = S_PUT;
        end else begin
          cmd_o.op = CMD_RD;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        priority if (!sts_i.op_free && sts_i.hit_alloc && sts_i.can_split) begin
          cmd_o.op = CMD_HOLD;
          state_d  = S_UP_RD;
        end else if (!sts_i.op_free && sts_i.hit_alloc) begin
          cmd_o.op = CMD_TAKE;
          state_d  = S_PUT;
        end else if (sts_i.op_free && sts_i.hit_free) begin
          cmd_o.op = CMD_HOLD;
          state_d  = S_NX;
        end else begin
          cmd_o.op = CMD_ADV;
          state_d  = S_RD;
        end
      end
      S_UP_RD: begin
        if (sts_i.up_more) begin
          cmd_o.op = CMD_UP_RD;
          state_d  = S_UP_WR;
        end else begin
          state_d = S_SPL1;
        end
      end
      S_UP_WR: begin
        cmd_o.op = CMD_UP_WR;
        state_d  = S_UP_RD;
      end
      S_SPL1: begin
        cmd_o.op = CMD_SPL1;
        state_d  = S_SPL0;
      end
      S_SPL0: begin
        cmd_o.op = CMD_SPL0;
        state_d  = S_PUT;
      end
      S_NX: begin
        cmd_o.op = CMD_NEXT;
        state_d  = S_MRG;
      end
      S_MRG: begin
        cmd_o.op = CMD_MERGE;
        state_d  = S_DN_RD;
      end
      S_DN_RD: begin
        if (sts_i.dn_more) begin
          cmd_o.op = CMD_DN_RD;
          state_d  = S_DN_WR;
        end else begin
          cmd_o.op = CMD_DN_END;
          state_d  = S_PUT;
        end
      end
      S_DN_WR: begin
        cmd_o.op = CMD_DN_WR;
        state_d  = S_DN_RD;
      end
      S_PUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = CMD_PUT;
          state_d  = S_IDLE;
          stall_d  = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      stall_q <= 1'b1;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

>>> rtl/core/ffha_dp.sv
// Datapath: block table memory, scan/shift pointers, merge math and result register.
`timescale 1ns / 1ps
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int unsigned ARENA_BYTES  = ARENA_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  logic [31:0] heap_base_i,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(ARENA_BYTES) + 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PW = CW + 1;
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam logic [31:0] H32 = 32'(HEADER_BYTES);

  typedef struct packed {
    logic [AW-1:0] off;
    logic [AW-1:0] size;
    logic          free;
  } ent_t;

  ent_t mem_q [MAX_BLOCKS];
  ent_t rdata_q, cur_q, prev_q;

  logic               op_q;
  logic [RSIZE_W-1:0] size_q;
  logic [31:0]        ptr_q;
  logic [CW-1:0]      count_q, idx_q;
  logic [PW-1:0]      ptr2_q;
  logic [1:0]         k_q;
  logic               prev_v_q, nx_v_q;
  logic [1:0]         res_st_q;
  logic [31:0]        res_addr_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  ent_t          wr_data;

  logic [31:0]   req32, r_size32, m32, pm32;
  logic [CW-1:0] idx_nx;
  logic          nf, pf;
  logic [RSIZE_W-1:0] round_sz;

  assign req32    = 32'(size_q);
  assign r_size32 = 32'(rdata_q.size);
  assign idx_nx   = idx_q + CW'(1);
  assign nf       = nx_v_q && rdata_q.free;
  assign pf       = prev_v_q && prev_q.free;
  assign m32      = 32'(cur_q.size) + (nf ? (H32 + r_size32) : 32'd0);
  assign pm32     = 32'(prev_q.size) + H32 + m32;
  assign round_sz = ({1'b0, in_item_i.request_size} + RSIZE_W'(7)) & ~RSIZE_W'(7);

  always_comb begin
    sts_o.op_free   = (op_q == OP_FREE);
    sts_o.stop      = (idx_q >= count_q) || ((op_q == OP_ALLOC) && (size_q == '0)) ||
                      ((op_q == OP_FREE) && (ptr_q == 32'd0));
    sts_o.hit_alloc = rdata_q.free && (r_size32 >= req32);
    sts_o.can_split = (r_size32 >= req32 + H32 + 32'd8) && (count_q < CW'(MAX_BLOCKS));
    sts_o.hit_free  = (heap_base_i + 32'(rdata_q.off) + H32) == ptr_q;
    sts_o.up_more   = ptr2_q > {1'b0, idx_q};
    sts_o.dn_more   = (k_q != 2'd0) && (ptr2_q < {1'b0, count_q});
    sts_o.out_busy  = out_valid_q && out_stall_i;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[IW-1:0];
    wr_data = rdata_q;
    unique case (cmd_i.op)
      CMD_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '{off: '0, size: AW'(ARENA_BYTES - HEADER_BYTES), free: 1'b1};
      end
      CMD_RD: rd_en = 1'b1;
      CMD_TAKE: begin
        wr_en        = 1'b1;
        wr_data.free = 1'b0;
      end
      CMD_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr2_q[IW-1:0];
      end
      CMD_UP_WR: begin
        wr_en   = 1'b1;
        wr_addr = IW'(ptr2_q + PW'(1));
      end
      CMD_SPL1: begin
        wr_en   = 1'b1;
        wr_addr = idx_nx[IW-1:0];
        wr_data = '{off:  AW'(32'(cur_q.off) + H32 + req32),
                    size: AW'(32'(cur_q.size) - req32 - H32), free: 1'b1};
      end
      CMD_SPL0: begin
        wr_en   = 1'b1;
        wr_data = '{off: cur_q.off, size: AW'(req32), free: 1'b0};
      end
      CMD_NEXT: begin
        rd_en   = (idx_nx < count_q);
        rd_addr = idx_nx[IW-1:0];
      end
      CMD_MERGE: begin
        wr_en = 1'b1;
        if (pf) begin
          wr_addr = IW'(idx_q - CW'(1));
          wr_data = '{off: prev_q.off, size: AW'(pm32), free: 1'b1};
        end else begin
          wr_data = '{off: cur_q.off, size: AW'(m32), free: 1'b1};
        end
      end
      CMD_DN_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr2_q[IW-1:0];
      end
      CMD_DN_WR: begin
        wr_en   = 1'b1;
        wr_addr = IW'(ptr2_q - PW'(k_q));
      end
      default: ;
    endcase
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CMD_LOAD: begin
        op_q     <= in_item_i.opcode;
        size_q   <= round_sz;
        ptr_q    <= in_item_i.free_address;
        idx_q    <= '0;
        prev_v_q <= 1'b0;
      end
      CMD_FAIL: begin
        res_addr_q <= 32'd0;
        if (op_q == OP_ALLOC) res_st_q <= ST_NOFIT;
        else if (ptr_q == 32'd0) res_st_q <= ST_NULL;
        else res_st_q <= ST_UNKNOWN;
      end
      CMD_TAKE: begin
        res_st_q   <= ST_OK;
        res_addr_q <= heap_base_i + 32'(rdata_q.off) + H32;
      end
      CMD_HOLD: begin
        cur_q  <= rdata_q;
        ptr2_q <= PW'(count_q - CW'(1));
      end
      CMD_ADV: begin
        prev_q   <= rdata_q;
        prev_v_q <= 1'b1;
        idx_q    <= idx_nx;
      end
      CMD_UP_WR: ptr2_q <= ptr2_q - PW'(1);
      CMD_SPL0: begin
        res_st_q   <= ST_OK;
        res_addr_q <= heap_base_i + 32'(cur_q.off) + H32;
      end
      CMD_NEXT: nx_v_q <= (idx_nx < count_q);
      CMD_MERGE: begin
        res_st_q   <= ST_OK;
        res_addr_q <= 32'd0;
        if (pf) begin
          k_q    <= nf ? 2'd2 : 2'd1;
          ptr2_q <= {1'b0, idx_q} + (nf ? PW'(2) : PW'(1));
        end else begin
          k_q    <= nf ? 2'd1 : 2'd0;
          ptr2_q <= {1'b0, idx_q} + (nf ? PW'(2) : PW'(1));
        end
      end
      CMD_DN_WR: ptr2_q <= ptr2_q + PW'(1);
      CMD_PUT: out_q <= '{status: res_st_q, address: res_addr_q};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == CMD_SPL0) count_q <= count_q + CW'(1);
      else if (cmd_i.op == CMD_DN_END) count_q <= count_q - CW'(k_q);
      if (cmd_i.op == CMD_PUT) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(1)) && (count_q <= CW'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_split_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_SPL0) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("split did not add a block");

  a_put_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_PUT) |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  a_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_UP_RD) |-> (count_q < CW'(MAX_BLOCKS)))
    else $error("split started on a full table");

endmodule

>>> rtl/core/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: APB register, sequencer and datapath.
`timescale 1ns / 1ps
// Each item is one allocate or free against an arena kept as an address-ordered
// table of blocks in a single-port-style RAM (one write, one registered read per
// cycle). An item walks the table one entry at a time, with a read state and a
// check state per entry, until it hits; a split then shifts the entries after
// the hit up by one and a free that merges shifts the rest down by one or two,
// with a read and a write per moved entry. One item is in work at a time; the
// result sits in an output register, so the next item is taken while the
// previous result still waits. After reset the block writes the initial arena
// entry in its init state before it takes items; heap_base may be written any
// time the block is idle and only moves the payload addresses.
module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int unsigned ARENA_BYTES  = ARENA_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] heap_base_q;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;

  // heap_base lives at byte address 0; anything at 4 is unmapped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= HEAP_BASE_RST;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      heap_base_q <= pwdata;
    end
  end

  assign prdata = paddr[2] ? 32'd0 : heap_base_q;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffha_dp #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .heap_base_i (heap_base_q),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> tb/first_fit_heap_allocator_top_test.sv
// Self-checking testbench for the first-fit heap allocator top level.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top_test;
  import ffha_pkg::*;

  localparam int unsigned ARENA  = ARENA_BYTES_DEF;
  localparam int unsigned HDR    = HEADER_BYTES_DEF;
  localparam int unsigned MAXBLK = MAX_BLOCKS_DEF;
  localparam logic [PADDR_W-1:0] ADDR_HEAP_BASE = '0;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_item_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  first_fit_heap_allocator_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block table: offset, payload size, free mark per entry.
  logic [31:0] shd_off [MAXBLK];
  logic [31:0] shd_size[MAXBLK];
  logic        shd_free[MAXBLK];
  int unsigned shd_count;
  logic [31:0] shd_base;

  in_item_t    pending_q[$];   // items waiting for the driver
  out_item_t   grant_q[$];     // expected results, oldest first
  logic [31:0] live_q[$];      // payload addresses believed allocated
  int unsigned n_fail, n_sent, n_got, n_alloc_ok, n_free_ok, n_nofit, n_unknown;
  bit          hold_rx;        // forces a long receiver hold-off
  bit          rand_idle = 1'b1;
  bit          tx_took;        // item taken at the last rising edge

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    n_fail++;
  endtask

  function automatic void table_reset();
    shd_off[0] = 0; shd_size[0] = ARENA - HDR; shd_free[0] = 1'b1;
    shd_count = 1;
  endfunction

  function automatic void table_remove(int unsigned idx);
    for (int unsigned k = idx; k + 1 < shd_count; k++) begin
      shd_off[k] = shd_off[k+1]; shd_size[k] = shd_size[k+1]; shd_free[k] = shd_free[k+1];
    end
    shd_count--;
  endfunction

  // Apply one item to the shadow table and return the result it should give.
  function automatic out_item_t predict_heap(in_item_t it);
    out_item_t   r;
    logic [31:0] sz;
    int unsigned i;
    r = '0;
    if (it.opcode == OP_ALLOC) begin
      r.status = ST_NOFIT;
      if (it.request_size != 0) begin
        sz = (32'(it.request_size) + 7) & ~32'd7;
        for (i = 0; i < shd_count; i++)
          if (shd_free[i] && shd_size[i] >= sz) break;
        if (i < shd_count) begin
          if (shd_size[i] >= sz + HDR + 8 && shd_count < MAXBLK) begin
            for (int unsigned k = shd_count; k > i + 1; k--) begin
              shd_off[k] = shd_off[k-1]; shd_size[k] = shd_size[k-1];
              shd_free[k] = shd_free[k-1];
            end
            shd_off[i+1] = shd_off[i] + HDR + sz;
            shd_size[i+1] = shd_size[i] - sz - HDR;
            shd_free[i+1] = 1'b1;
            shd_count++;
            shd_size[i] = sz;
          end
          shd_free[i] = 1'b0;
          r.status = ST_OK;
          r.address = shd_base + shd_off[i] + HDR;
        end
      end
    end else if (it.free_address == 0) begin
      r.status = ST_NULL;
    end else begin
      for (i = 0; i < shd_count; i++)
        if (shd_base + shd_off[i] + HDR == it.free_address) break;
      if (i >= shd_count) r.status = ST_UNKNOWN;
      else begin
        r.status = ST_OK;
        shd_free[i] = 1'b1;
        if (i + 1 < shd_count && shd_free[i+1]) begin
          shd_size[i] += HDR + shd_size[i+1];
          table_remove(i + 1);
        end
        if (i > 0 && shd_free[i-1]) begin
          shd_size[i-1] += HDR + shd_size[i];
          table_remove(i);
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned idle_len();
    if (!rand_idle || $urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
  endfunction

  // Driver: expectation is computed at acceptance, so prediction order matches.
  int unsigned tx_gap;
  always @(posedge clk_i) begin
    tx_took = in_valid_i && !in_stall_o;
    if (tx_took) begin
      grant_q.push_back(predict_heap(in_item_i));
      n_sent++;
    end
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (tx_took || !in_valid_i) begin
        if (tx_took) pending_q.pop_front();
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_item_i  <= pending_q[0];
          in_valid_i <= 1'b1;
          tx_gap     <= idle_len();
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor plus receiver stall.
  int unsigned rx_gap;
  always @(posedge clk_i) begin
    out_item_t want;
    if (out_valid_o && !out_stall_i) begin
      n_got++;
      if (grant_q.size() == 0) report_mismatch("unexpected result", out_item_o.address, 0);
      else begin
        want = grant_q.pop_front();
        if (out_item_o.status !== want.status)
          report_mismatch("status", 32'(out_item_o.status), 32'(want.status));
        if (out_item_o.address !== want.address)
          report_mismatch("address", out_item_o.address, want.address);
        if (want.status == ST_OK && want.address != 0) live_q.push_back(want.address);
        case (want.status)
          ST_NOFIT:   n_nofit++;
          ST_UNKNOWN: n_unknown++;
          default:    if (want.address != 0) n_alloc_ok++; else n_free_ok++;
        endcase
      end
    end
  end
  always @(negedge clk_i) begin
    if (hold_rx) out_stall_i <= 1'b1;
    else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1; out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0; rx_gap <= idle_len();
    end
  end

  task automatic apb_write(input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_HEAP_BASE; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    shd_base = val;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Wait until every expected result is back, then let the walk settle.
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || grant_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic in_item_t mk_alloc(int unsigned sz);
    in_item_t it;
    it = '0; it.opcode = OP_ALLOC; it.request_size = sz[REQ_W-1:0];
    it.free_address = $urandom;  // ignored on allocate, but toggles bits
    return it;
  endfunction

  function automatic in_item_t mk_free(logic [31:0] a);
    in_item_t it;
    it = '0; it.opcode = OP_FREE; it.free_address = a;
    it.request_size = REQ_W'($urandom);
    return it;
  endfunction

  // Random mix: mostly small allocations and frees of live pointers.
  task automatic random_phase(int unsigned cnt);
    int unsigned pick, k;
    for (int unsigned n = 0; n < cnt; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pending_q.push_back(mk_alloc($urandom_range(0, 19) == 0 ?
          $urandom_range(0, 2**REQ_W - 1) : $urandom_range(1, 600)));
      end else if (pick < 88 && live_q.size() > 0) begin
        k = $urandom_range(0, live_q.size() - 1);
        pending_q.push_back(mk_free(live_q[k]));
        live_q.delete(k);
      end else if (pick < 92) pending_q.push_back(mk_free(32'h0));
      else if (pick < 97) pending_q.push_back(mk_free($urandom));
      else pending_q.push_back(mk_free(shd_base + HDR + 8 * $urandom_range(1, 64)));
      // keep the queue shallow so frees use pointers that came back already
      if (pending_q.size() > 4)
        while (pending_q.size() > 1) @(posedge clk_i);
    end
  endtask

  initial begin
    shd_base = HEAP_BASE_RST;
    table_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: extremes, zero size, no fit, null/unknown/repeated free.
    rand_idle = 1'b0;
    pending_q.push_back(mk_alloc(0));
    pending_q.push_back(mk_alloc(1));
    pending_q.push_back(mk_alloc(2**REQ_W - 1));
    pending_q.push_back(mk_alloc(ARENA));
    pending_q.push_back(mk_alloc(8));
    pending_q.push_back(mk_alloc(13));
    pending_q.push_back(mk_free(32'h0));
    pending_q.push_back(mk_free(32'hFFFF_FFFF));
    pending_q.push_back(mk_free(HEAP_BASE_RST + HDR + 8 + HDR));   // second block
    pending_q.push_back(mk_free(HEAP_BASE_RST + HDR + 8 + HDR));   // repeated free
    pending_q.push_back(mk_free(HEAP_BASE_RST + HDR));
    pending_q.push_back(mk_alloc(ARENA - HDR));                    // whole arena
    pending_q.push_back(mk_free(HEAP_BASE_RST + HDR));
    drain();
    live_q.delete();

    // Base at the top of the address space: payload addresses wrap.
    apb_write(32'hFFFF_FFF0);
    pending_q.push_back(mk_alloc(24));
    pending_q.push_back(mk_alloc(40));
    pending_q.push_back(mk_free(32'hFFFF_FFF0 + HDR));
    drain();

    // Long receiver hold-off while the sender keeps offering items.
    rand_idle = 1'b1;
    hold_rx = 1'b1;
    for (int k = 0; k < 6; k++) pending_q.push_back(mk_alloc($urandom_range(1, 64)));
    repeat (300) @(posedge clk_i);
    hold_rx = 1'b0;
    drain();

    random_phase(180);
    drain();
    apb_write(32'h0);
    random_phase(180);
    drain();
    apb_write($urandom);
    random_phase(200);
    drain();

    $display("covered %0d items: %0d allocations granted, %0d frees, %0d no-fit, %0d unknown",
             n_sent, n_alloc_ok, n_free_ok, n_nofit, n_unknown);
    $display("heap_base moved through reset, wrap, zero and random values; %0d results", n_got);
    if (n_fail == 0) $display("[first_fit_heap_allocator_top] OK");
    else $display("[first_fit_heap_allocator_top] ERROR");
    $finish;
  end

  initial begin
    #100ms;
    $display("[first_fit_heap_allocator_top] ERROR");
    $finish;
  end

endmodule
